>>> hw/rtl/lrgd_pkg.sv
// shared types and constants of the line, rectangle and gradient drawer
package lrgd_pkg;

  localparam int OX_W  = 12;
  localparam int EXT_W = 13;
  localparam int PX_W  = 13;
  localparam int COL_W = 32;
  localparam int RGB_W = 24;

  typedef enum logic [1:0] {
    MODE_HLINE,
    MODE_VLINE,
    MODE_RECT,
    MODE_GRAD
  } mode_t;

  typedef enum logic [2:0] {
    REG_DRAW_MODE,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_EXTENT_W,
    REG_EXTENT_H,
    REG_COLOR_A,
    REG_COLOR_B,
    REG_GRAD_STEPS
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_LOAD,
    ST_ITER,
    ST_STORE
  } step_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_NO_GRAD,
    C_DIV_MORE,
    C_CHAN_MORE
  } cond_t;

  localparam logic [1:0] LAST_CHAN = 2'd2;

  typedef struct packed {
    logic   accept;
    logic   div_load;
    logic   div_iter;
    logic   div_store;
    cond_t  cond;
    step_t  target;
  } ucw_t;

  typedef struct packed {
    logic       accept;
    logic       div_load;
    logic       div_iter;
    logic       div_store;
    logic [1:0] chan;
  } seq_ctrl_t;

  typedef struct packed {
    logic start_grad;
    logic div_more;
  } seq_stat_t;

  typedef struct packed {
    logic start_req;
  } in_word_t;

  typedef struct packed {
    logic [PX_W-1:0]  px_x;
    logic [PX_W-1:0]  px_y;
    logic [COL_W-1:0] px_color;
    logic             is_last;
    logic [7:0]       end_r;
    logic [7:0]       end_g;
    logic [7:0]       end_b;
  } out_word_t;

  typedef struct packed {
    cfg_idx_t         index;
    logic [COL_W-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    mode_t            draw_mode;
    logic [OX_W-1:0]  origin_x;
    logic [OX_W-1:0]  origin_y;
    logic [EXT_W-1:0] extent_w;
    logic [EXT_W-1:0] extent_h;
    logic [COL_W-1:0] color_a;
    logic [RGB_W-1:0] color_b;
    logic [EXT_W-1:0] grad_steps;
  } cfg_regs_t;

endpackage

>>> hw/rtl/lrgd_stream_if.sv
// valid/ready channel interface carrying one word of type T
interface lrgd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/line_rect_gradient_drawer_core.sv
// top level of the line, rectangle outline and gradient fill drawer
//
//  channel   dir   word                                   handshake
//  in_chan   in    start_req (1 start, 0 tick)            valid/ready
//  out_chan  out   px_x px_y px_color is_last end_r/g/b   valid/ready
//  cfg_chan  in    index, wdata                           valid/ready, ready always high
//
// a tick yields one pixel while a command is drawing
// a gradient start then runs the shared divider for each color channel in turn,
// one quotient bit per cycle, input held off meanwhile
// synchronous active-low reset, no clearing pass
// a stalled output word blocks the next tick only until it is taken
module line_rect_gradient_drawer_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic          clk,
  input logic          rst_n,
  lrgd_stream_if.sink   in_chan,
  lrgd_stream_if.source out_chan,
  lrgd_stream_if.sink   cfg_chan
);
  import lrgd_pkg::*;

  localparam int AW = FRAC_BITS + 8;

  cfg_regs_t   regs_r, regs_nxt;
  seq_ctrl_t   ctrl;
  seq_stat_t   stat;
  logic [AW-1:0] div_num, quot;
  logic        room, in_fire, start_grad, div_more;
  cfg_word_t   cw;

  assign cw             = cfg_chan.data;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_chan.valid) begin
      case (cw.index)
        REG_DRAW_MODE:  regs_nxt.draw_mode  = mode_t'(cw.wdata[1:0]);
        REG_ORIGIN_X:   regs_nxt.origin_x   = cw.wdata[OX_W-1:0];
        REG_ORIGIN_Y:   regs_nxt.origin_y   = cw.wdata[OX_W-1:0];
        REG_EXTENT_W:   regs_nxt.extent_w   = cw.wdata[EXT_W-1:0];
        REG_EXTENT_H:   regs_nxt.extent_h   = cw.wdata[EXT_W-1:0];
        REG_COLOR_A:    regs_nxt.color_a    = cw.wdata;
        REG_COLOR_B:    regs_nxt.color_b    = cw.wdata[RGB_W-1:0];
        REG_GRAD_STEPS: regs_nxt.grad_steps = cw.wdata[EXT_W-1:0];
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{draw_mode: MODE_HLINE, origin_x: '0, origin_y: '0, extent_w: '0,
                  extent_h: '0, color_a: '0, color_b: '0, grad_steps: EXT_W'(1)};
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign in_chan.ready = ctrl.accept && room;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign stat = '{start_grad: start_grad, div_more: div_more};

  lrgd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  lrgd_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .num   (div_num),
    .den   (regs_r.grad_steps),
    .quot  (quot),
    .more  (div_more)
  );

  lrgd_pix #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pix (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs_r),
    .ctrl       (ctrl),
    .in_fire    (in_fire),
    .in_start   (in_chan.data.start_req),
    .quot       (quot),
    .div_num    (div_num),
    .start_grad (start_grad),
    .room       (room),
    .out_valid  (out_chan.valid),
    .out_word   (out_chan.data),
    .out_ready  (out_chan.ready)
  );
endmodule

>>> hw/rtl/lrgd_div.sv
// restoring divider, one quotient bit per cycle, for the gradient step
module lrgd_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lrgd_pkg::seq_ctrl_t      ctrl,
  input  logic [FRAC_BITS+7:0]     num,
  input  logic [lrgd_pkg::EXT_W-1:0] den,
  output logic [FRAC_BITS+7:0]     quot,
  output logic                     more
);
  import lrgd_pkg::*;

  localparam int AW = FRAC_BITS + 8;
  localparam int CW = $clog2(AW + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    num_r, num_nxt;
  logic [AW-1:0]    quot_r, quot_nxt;
  logic [EXT_W-1:0] rem_r, rem_nxt;
  logic [EXT_W-1:0] den_r, den_nxt;
  logic [EXT_W:0]   trial;
  logic             qbit;

  always_comb begin
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, num_r[AW-1]};
    qbit     = trial >= {1'b0, den_r};
    if (ctrl.div_load) begin
      cnt_nxt  = CW'(AW);
      num_nxt  = num;
      quot_nxt = '0;
      rem_nxt  = '0;
      den_nxt  = (den == '0) ? EXT_W'(1) : den;
    end else if (ctrl.div_iter) begin
      cnt_nxt  = cnt_r - CW'(1);
      num_nxt  = {num_r[AW-2:0], 1'b0};
      quot_nxt = {quot_r[AW-2:0], qbit};
      rem_nxt  = qbit ? EXT_W'(trial - {1'b0, den_r}) : trial[EXT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign quot = quot_r;
  assign more = cnt_r > CW'(1);

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_iter |=> rem_r < den_r)
    else $error("divider remainder not below divisor");
  a_cnt_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_load |=> cnt_r == CW'(AW))
    else $error("divider count not loaded");
  a_iter_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_iter |-> cnt_r != '0)
    else $error("divider stepped past its last bit");
endmodule

>>> hw/rtl/lrgd_seq.sv
// microcode sequencer: step counter, control rom and jump conditions
module lrgd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  lrgd_pkg::seq_stat_t stat,
  output lrgd_pkg::seq_ctrl_t ctrl
);
  import lrgd_pkg::*;

  step_t      upc_r, upc_nxt;
  logic [1:0] chan_r, chan_nxt;
  ucw_t       uw;
  logic       jump;

  function automatic ucw_t rom(step_t s);
    ucw_t w;
    w = '0;
    case (s)
      ST_WAIT: begin
        w.accept = 1'b1;
        w.cond   = C_NO_GRAD;
        w.target = ST_WAIT;
      end
      ST_LOAD: begin
        w.div_load = 1'b1;
        w.cond     = C_NEXT;
        w.target   = ST_LOAD;
      end
      ST_ITER: begin
        w.div_iter = 1'b1;
        w.cond     = C_DIV_MORE;
        w.target   = ST_ITER;
      end
      ST_STORE: begin
        w.div_store = 1'b1;
        w.cond      = C_CHAN_MORE;
        w.target    = ST_LOAD;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // outputs of the current step
  always_comb begin
    uw             = rom(upc_r);
    ctrl.accept    = uw.accept;
    ctrl.div_load  = uw.div_load;
    ctrl.div_iter  = uw.div_iter;
    ctrl.div_store = uw.div_store;
    ctrl.chan      = chan_r;
  end

  // next step: jump target or fall through, store wraps to wait
  always_comb begin
    case (uw.cond)
      C_NEXT:      jump = 1'b0;
      C_NO_GRAD:   jump = !stat.start_grad;
      C_DIV_MORE:  jump = stat.div_more;
      C_CHAN_MORE: jump = chan_r != LAST_CHAN;
      default:     jump = 1'b0;
    endcase
    upc_nxt  = jump ? uw.target : step_t'(2'(upc_r) + 2'd1);
    chan_nxt = chan_r;
    if (upc_r == ST_WAIT) begin
      chan_nxt = '0;
    end else if (uw.div_store && jump) begin
      chan_nxt = chan_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= ST_WAIT;
      chan_r <= '0;
    end else begin
      upc_r  <= upc_nxt;
      chan_r <= chan_nxt;
    end
  end

  a_load_then_iter: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == ST_LOAD |=> upc_r == ST_ITER)
    else $error("load step not followed by iterate");
  a_done_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == ST_STORE && chan_r == LAST_CHAN |=> upc_r == ST_WAIT)
    else $error("last channel store did not return to wait");
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r != 2'd3)
    else $error("channel index out of range");
endmodule

>>> hw/rtl/lrgd_pix.sv
// pixel walker: counters, gradient accumulators and the output register
module lrgd_pix #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrgd_pkg::cfg_regs_t regs,
  input  lrgd_pkg::seq_ctrl_t ctrl,
  input  logic                in_fire,
  input  logic                in_start,
  input  logic [FRAC_BITS+7:0] quot,
  output logic [FRAC_BITS+7:0] div_num,
  output logic                start_grad,
  output logic                room,
  output logic                out_valid,
  output lrgd_pkg::out_word_t out_word,
  input  logic                out_ready
);
  import lrgd_pkg::*;

  localparam int AW = FRAC_BITS + 8;
  localparam logic [AW-1:0] ACC_MAX = '1;
  localparam int EXT_LIM = 1 << COORD_BITS;
  localparam logic [OX_W-1:0] ORG_MASK =
    (COORD_BITS >= OX_W) ? '1 : OX_W'((1 << COORD_BITS) - 1);

  function automatic logic [EXT_W-1:0] lim(logic [EXT_W-1:0] v);
    if (int'(v) > EXT_LIM) begin
      return EXT_W'(EXT_LIM);
    end
    return v;
  endfunction

  logic [EXT_W-1:0] w, h;
  logic [PX_W-1:0]  x, y;
  logic             empty, load, last;

  logic             busy_r, busy_nxt;
  logic             phase_r, phase_nxt;
  logic             tog_r, tog_nxt;
  logic             dir_r, dir_nxt;
  logic [PX_W-1:0]  cc_r, cc_nxt, cc_inc;
  logic [PX_W-1:0]  rc_r, rc_nxt, rc_inc;
  logic             row_done;

  logic [AW-1:0]    acc_r [3];
  logic [AW-1:0]    acc_nxt [3];
  logic [AW-1:0]    acc_sat [3];
  logic [AW:0]      acc_sum [3];
  logic [AW-1:0]    mag_r [3];
  logic             neg_r [3];

  logic [7:0]       top_c, bot_c, absd;
  logic             dneg;

  logic             ov_r;
  out_word_t        ow_r, word_nxt;

  assign w = lim(regs.extent_w);
  assign h = lim(regs.extent_h);
  assign x = {1'b0, regs.origin_x & ORG_MASK};
  assign y = {1'b0, regs.origin_y & ORG_MASK};

  assign empty      = (w == '0) || (regs.draw_mode[1] && h == '0);
  assign start_grad = in_fire && in_start && regs.draw_mode == MODE_GRAD && !empty;
  assign room       = !ov_r || out_ready;
  assign load       = in_fire && !in_start && busy_r;

  // channel picked for the divider
  always_comb begin
    case (ctrl.chan)
      2'd0: begin
        top_c = regs.color_a[23:16];
        bot_c = regs.color_b[23:16];
      end
      2'd1: begin
        top_c = regs.color_a[15:8];
        bot_c = regs.color_b[15:8];
      end
      default: begin
        top_c = regs.color_a[7:0];
        bot_c = regs.color_b[7:0];
      end
    endcase
    dneg    = top_c < bot_c;
    absd    = dneg ? bot_c - top_c : top_c - bot_c;
    div_num = {absd, {FRAC_BITS{1'b0}}};
  end

  // saturating row step of each channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_sum[k] = {1'b0, acc_r[k]} + {1'b0, mag_r[k]};
      if (neg_r[k]) begin
        acc_sat[k] = (acc_r[k] >= mag_r[k]) ? acc_r[k] - mag_r[k] : '0;
      end else begin
        acc_sat[k] = acc_sum[k][AW] ? ACC_MAX : acc_sum[k][AW-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    tog_nxt   = tog_r;
    dir_nxt   = dir_r;
    cc_nxt    = cc_r;
    rc_nxt    = rc_r;
    cc_inc    = cc_r + PX_W'(1);
    rc_inc    = rc_r + PX_W'(1);
    row_done  = 1'b0;
    last      = 1'b0;
    word_nxt  = '0;
    word_nxt.px_color = regs.color_a;
    if (in_fire && in_start) begin
      busy_nxt  = !empty;
      phase_nxt = (regs.draw_mode == MODE_RECT) && !(w > EXT_W'(2));
      tog_nxt   = 1'b0;
      dir_nxt   = 1'b0;
      cc_nxt    = '0;
      rc_nxt    = '0;
    end else if (load) begin
      case (regs.draw_mode)
        MODE_HLINE: begin
          word_nxt.px_x = x + cc_r;
          word_nxt.px_y = y;
          cc_nxt = cc_inc;
          last   = cc_inc >= w;
        end
        MODE_VLINE: begin
          word_nxt.px_x = x;
          word_nxt.px_y = y + cc_r;
          cc_nxt = cc_inc;
          last   = cc_inc >= w;
        end
        MODE_RECT: begin
          if (!phase_r) begin
            word_nxt.px_x = x + PX_W'(1) + cc_r;
            word_nxt.px_y = tog_r ? y + h - PX_W'(1) : y;
            if (tog_r) begin
              cc_nxt = cc_inc;
              if (w <= EXT_W'(2) || cc_inc >= w - EXT_W'(2)) begin
                phase_nxt = 1'b1;
                rc_nxt    = '0;
              end
            end
          end else begin
            word_nxt.px_x = tog_r ? x : ((w >= EXT_W'(1)) ? x + w - PX_W'(1) : x);
            word_nxt.px_y = y + rc_r;
            if (tog_r) begin
              rc_nxt = rc_inc;
              last   = rc_inc >= h;
            end
          end
          tog_nxt = !tog_r;
        end
        MODE_GRAD: begin
          word_nxt.px_color = {8'd0, acc_r[0][AW-1 -: 8], acc_r[1][AW-1 -: 8],
                               acc_r[2][AW-1 -: 8]};
          word_nxt.px_x = dir_r ? x + w - PX_W'(1) - cc_r : x + cc_r;
          word_nxt.px_y = y + h - rc_r;
          cc_nxt = cc_inc;
          if (cc_inc >= w) begin
            cc_nxt   = '0;
            row_done = 1'b1;
            rc_nxt   = rc_inc;
            dir_nxt  = !dir_r;
            if (rc_inc >= h) begin
              last           = 1'b1;
              word_nxt.end_r = acc_sat[0][AW-1 -: 8];
              word_nxt.end_g = acc_sat[1][AW-1 -: 8];
              word_nxt.end_b = acc_sat[2][AW-1 -: 8];
            end
          end
        end
        default: last = 1'b0;
      endcase
      word_nxt.is_last = last;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = acc_r[k];
      if (ctrl.div_store && ctrl.chan == 2'(k)) begin
        acc_nxt[k] = {bot_c, {FRAC_BITS{1'b0}}};
      end else if (row_done) begin
        acc_nxt[k] = acc_sat[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      tog_r   <= 1'b0;
      dir_r   <= 1'b0;
      cc_r    <= '0;
      rc_r    <= '0;
      ov_r    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= '0;
        mag_r[k] <= '0;
        neg_r[k] <= 1'b0;
      end
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      tog_r   <= tog_nxt;
      dir_r   <= dir_nxt;
      cc_r    <= cc_nxt;
      rc_r    <= rc_nxt;
      ov_r    <= load ? 1'b1 : (out_ready ? 1'b0 : ov_r);
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= acc_nxt[k];
        if (ctrl.div_store && ctrl.chan == 2'(k)) begin
          mag_r[k] <= quot;
          neg_r[k] <= dneg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ow_r <= word_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load && word_nxt.is_last |=> !busy_r)
    else $error("command still busy after last pixel");
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_start && empty |=> !busy_r)
    else $error("empty command left the walker busy");
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_start && !busy_r |=> !ov_r)
    else $error("pixel produced while idle");
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ow_r.is_last |-> ow_r.end_r == 8'd0 && ow_r.end_g == 8'd0 &&
      ow_r.end_b == 8'd0)
    else $error("end color on a pixel that is not last");
endmodule

>>> test/testbench.sv
// self-checking bench for the line, rectangle outline and gradient fill drawer
module testbench;
  import lrgd_pkg::*;

  localparam int ITEMS      = 1100;
  localparam int CALM_ITEMS = 150;
  localparam int DIV_WAIT   = 3 * (16 + 10) + 12;
  localparam logic signed [26:0] ACC_MAX = 27'sd16777215;

  typedef enum logic [1:0] {ROW_REG, ROW_START, ROW_TICK} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} chk_t;

  typedef struct {
    row_kind_t        kind;
    cfg_idx_t         idx;
    logic [31:0]      wdata;
    chk_t             chk;
    out_word_t        word;
  } row_t;

  logic clk;
  logic rst_n;

  lrgd_stream_if #(.T(in_word_t))  in_if ();
  lrgd_stream_if #(.T(out_word_t)) out_if ();
  lrgd_stream_if #(.T(cfg_word_t)) cfg_if ();

  line_rect_gradient_drawer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // shadow of the registers and the drawing state
  cfg_regs_t             regs;
  bit                    drawing;
  bit                    on_columns;
  logic [12:0]           col_cnt;
  logic [12:0]           row_cnt;
  bit                    pair_second;
  bit                    walk_left;
  logic signed [25:0]    acc [3];
  logic signed [25:0]    stp [3];

  out_word_t pixel_q [$];
  row_t      script [$];
  out_word_t head_w;

  int  fail_cnt;
  int  n_items;
  int  n_starts;
  int  n_pixels;
  int  n_ends;
  int  stall_left;
  bit  calm;
  bit  quiet_tail;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void clear_drawer();
    regs = '0;
    regs.grad_steps = 13'd1;
    drawing = 0;
    on_columns = 0;
    col_cnt = '0;
    row_cnt = '0;
    pair_second = 0;
    walk_left = 0;
    for (int k = 0; k < 3; k++) begin
      acc[k] = '0;
      stp[k] = '0;
    end
  endfunction

  // one word into the drawer: returns 1 when it yields a pixel
  function automatic bit draw_step(input bit start_req, output out_word_t o);
    logic [12:0]        w, h, x, y, st;
    logic [7:0]         top, bot, diff;
    logic [23:0]        mag;
    logic signed [26:0] sum;
    bit                 last;
    w = (regs.extent_w > 13'd4096) ? 13'd4096 : regs.extent_w;
    h = (regs.extent_h > 13'd4096) ? 13'd4096 : regs.extent_h;
    x = {1'b0, regs.origin_x};
    y = {1'b0, regs.origin_y};
    o = '0;
    o.px_color = regs.color_a;
    last = 0;
    if (start_req) begin
      drawing = 0;
      on_columns = 0;
      col_cnt = '0;
      row_cnt = '0;
      pair_second = 0;
      walk_left = 0;
      if (w == 0 || (regs.draw_mode inside {MODE_RECT, MODE_GRAD} && h == 0))
        return 0;
      drawing = 1;
      if (regs.draw_mode == MODE_RECT) on_columns = (w <= 2);
      if (regs.draw_mode == MODE_GRAD) begin
        st = (regs.grad_steps == 0) ? 13'd1 : regs.grad_steps;
        for (int k = 0; k < 3; k++) begin
          top = regs.color_a[16-8*k +: 8];
          bot = regs.color_b[16-8*k +: 8];
          diff = (top >= bot) ? top - bot : bot - top;
          mag = {diff, 16'h0000} / st;
          stp[k] = (top >= bot) ? $signed({2'b00, mag}) : -$signed({2'b00, mag});
          acc[k] = {2'b00, bot, 16'h0000};
        end
      end
      return 0;
    end
    if (!drawing) return 0;
    case (regs.draw_mode)
      MODE_HLINE, MODE_VLINE: begin
        o.px_x = (regs.draw_mode == MODE_HLINE) ? x + col_cnt : x;
        o.px_y = (regs.draw_mode == MODE_HLINE) ? y : y + col_cnt;
        col_cnt = col_cnt + 1'b1;
        last = col_cnt >= w;
      end
      MODE_RECT: begin
        if (!on_columns) begin
          o.px_x = x + 13'd1 + col_cnt;
          o.px_y = pair_second ? y + h - 13'd1 : y;
          if (pair_second) begin
            col_cnt = col_cnt + 1'b1;
            if (w <= 2 || col_cnt >= w - 13'd2) begin
              on_columns = 1;
              row_cnt = '0;
            end
          end
        end else begin
          o.px_x = (pair_second || w == 0) ? x : x + w - 13'd1;
          o.px_y = y + row_cnt;
          if (pair_second) begin
            row_cnt = row_cnt + 1'b1;
            last = row_cnt >= h;
          end
        end
        pair_second = !pair_second;
      end
      default: begin
        o.px_color = {8'h00, acc[0][23:16], acc[1][23:16], acc[2][23:16]};
        o.px_x = walk_left ? x + w - 13'd1 - col_cnt : x + col_cnt;
        o.px_y = y + h - row_cnt;
        col_cnt = col_cnt + 1'b1;
        if (col_cnt >= w) begin
          col_cnt = '0;
          for (int k = 0; k < 3; k++) begin
            sum = 27'(acc[k]) + 27'(stp[k]);
            if (sum < 0) acc[k] = '0;
            else if (sum > ACC_MAX) acc[k] = ACC_MAX[25:0];
            else acc[k] = sum[25:0];
          end
          row_cnt = row_cnt + 1'b1;
          walk_left = !walk_left;
          if (row_cnt >= h) begin
            last = 1;
            o.end_r = acc[0][23:16];
            o.end_g = acc[1][23:16];
            o.end_b = acc[2][23:16];
          end
        end
      end
    endcase
    if (last) drawing = 0;
    o.is_last = last;
    return 1;
  endfunction

  function automatic logic [31:0] reg_value(cfg_idx_t idx);
    logic [31:0] v;
    int          pick;
    v = $urandom;
    pick = $urandom_range(0, 19);
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y: begin
        if (pick < 3) v[11:0] = '0;
        else if (pick < 6) v[11:0] = '1;
      end
      REG_EXTENT_W, REG_EXTENT_H: begin
        if (pick == 0) v[12:0] = '0;
        else if (pick < 3) v[12:0] = 13'($urandom_range(4090, 8191));
        else v[12:0] = 13'($urandom_range(0, 6));
      end
      REG_COLOR_A, REG_COLOR_B: begin
        if (pick == 0) v = '0;
        else if (pick == 1) v = '1;
      end
      REG_GRAD_STEPS: begin
        if (pick == 0) v[12:0] = 13'd4096;
        else if (pick < 3) v[12:0] = 13'($urandom);
        else v[12:0] = 13'($urandom_range(0, 6));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic out_word_t pix(int px, int py, logic [31:0] c, bit last);
    out_word_t o;
    o = '0;
    o.px_x = px[12:0];
    o.px_y = py[12:0];
    o.px_color = c;
    o.is_last = last;
    return o;
  endfunction

  function automatic row_t reg_row(cfg_idx_t idx, logic [31:0] v);
    row_t r;
    r = '{ROW_REG, idx, v, CHK_NONE, '0};
    return r;
  endfunction

  function automatic row_t go_row();
    row_t r;
    r = '{ROW_START, REG_DRAW_MODE, '0, CHK_NONE, '0};
    return r;
  endfunction

  function automatic row_t tick_row(chk_t c, out_word_t w);
    row_t r;
    r = '{ROW_TICK, REG_DRAW_MODE, '0, c, w};
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, wdata: v};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_DRAW_MODE:  regs.draw_mode  = mode_t'(v[1:0]);
      REG_ORIGIN_X:   regs.origin_x   = v[11:0];
      REG_ORIGIN_Y:   regs.origin_y   = v[11:0];
      REG_EXTENT_W:   regs.extent_w   = v[12:0];
      REG_EXTENT_H:   regs.extent_h   = v[12:0];
      REG_COLOR_A:    regs.color_a    = v;
      REG_COLOR_B:    regs.color_b    = v[23:0];
      REG_GRAD_STEPS: regs.grad_steps = v[12:0];
      default: ;
    endcase
  endtask

  task automatic push_word(bit s, chk_t chk, out_word_t typed);
    out_word_t w;
    bit        made;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{start_req: s};
    do @(posedge clk); while (!in_if.ready);
    if (s || drawing) n_items++;
    if (s) n_starts++;
    made = draw_step(s, w);
    quiet_tail = !made;
    if (chk == CHK_WORD) pixel_q.push_back(typed);
    else if (chk == CHK_MODEL && made) pixel_q.push_back(w);
  endtask

  // drain all pixels, then give a running divider time to finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (quiet_tail ? DIV_WAIT : 2) @(posedge clk);
  endtask

  task automatic field_err(string name, logic [31:0] e, logic [31:0] a);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0h got %0h", $time, name, e, a);
  endtask

  task automatic check_pixel(out_word_t e, out_word_t a);
    if (a.px_x !== e.px_x)         field_err("px_x", 32'(e.px_x), 32'(a.px_x));
    if (a.px_y !== e.px_y)         field_err("px_y", 32'(e.px_y), 32'(a.px_y));
    if (a.px_color !== e.px_color) field_err("px_color", e.px_color, a.px_color);
    if (a.is_last !== e.is_last)   field_err("is_last", 32'(e.is_last), 32'(a.is_last));
    if (a.end_r !== e.end_r)       field_err("end_r", 32'(e.end_r), 32'(a.end_r));
    if (a.end_g !== e.end_g)       field_err("end_g", 32'(e.end_g), 32'(a.end_g));
    if (a.end_b !== e.end_b)       field_err("end_b", 32'(e.end_b), 32'(a.end_b));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_pixels++;
      if (out_if.data.is_last) n_ends++;
      if (pixel_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected pixel word, expected none got x %0d y %0d color %0h",
                 $time, out_if.data.px_x, out_if.data.px_y, out_if.data.px_color);
      end else begin
        head_w = pixel_q.pop_front();
        check_pixel(head_w, out_if.data);
      end
    end
  end

  // random stall bursts on the pixel side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_if.ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(1, 8);
    end
  end

  initial begin
    #2000000;
    $display("FAIL line_rect_gradient_drawer_core");
    $finish;
  end

  initial begin
    int       cap;
    int       n;
    bit       prev_reg;
    cfg_idx_t idx;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    fail_cnt = 0;
    n_items = 0;
    n_starts = 0;
    n_pixels = 0;
    n_ends = 0;
    stall_left = 0;
    calm = 0;
    quiet_tail = 0;
    clear_drawer();

    script = '{
      tick_row(CHK_NONE, '0),
      go_row(),
      // line at the far corner, upper register bits set
      reg_row(REG_DRAW_MODE, 32'hFFFF_FFFC),
      reg_row(REG_ORIGIN_X, 32'hFFFF_FFFF),
      reg_row(REG_ORIGIN_Y, 32'hFFFF_FFFF),
      reg_row(REG_EXTENT_W, 32'h0000_0002),
      reg_row(REG_COLOR_A, 32'hFFFF_FFFF),
      go_row(),
      tick_row(CHK_WORD, pix(4095, 4095, 32'hFFFF_FFFF, 0)),
      tick_row(CHK_WORD, pix(4096, 4095, 32'hFFFF_FFFF, 1)),
      // vertical line, restarted while running
      reg_row(REG_DRAW_MODE, 32'hFFFF_FFFD),
      reg_row(REG_ORIGIN_X, 32'h0000_0005),
      reg_row(REG_ORIGIN_Y, 32'h0000_0000),
      reg_row(REG_EXTENT_W, 32'h0000_0003),
      reg_row(REG_COLOR_A, 32'h1234_5678),
      go_row(),
      tick_row(CHK_WORD, pix(5, 0, 32'h1234_5678, 0)),
      go_row(),
      tick_row(CHK_WORD, pix(5, 0, 32'h1234_5678, 0)),
      tick_row(CHK_WORD, pix(5, 1, 32'h1234_5678, 0)),
      tick_row(CHK_WORD, pix(5, 2, 32'h1234_5678, 1)),
      // outline one column wide
      reg_row(REG_DRAW_MODE, 32'h0000_0002),
      reg_row(REG_ORIGIN_X, 32'h0000_000A),
      reg_row(REG_ORIGIN_Y, 32'h0000_0014),
      reg_row(REG_EXTENT_W, 32'h0000_0001),
      reg_row(REG_EXTENT_H, 32'h0000_0002),
      reg_row(REG_COLOR_A, 32'hA5A5_A5A5),
      go_row(),
      tick_row(CHK_WORD, pix(10, 20, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(10, 20, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(10, 21, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(10, 21, 32'hA5A5_A5A5, 1)),
      // oversized height clamps, then shrinks while drawing
      reg_row(REG_EXTENT_W, 32'h0000_0003),
      reg_row(REG_EXTENT_H, 32'hFFFF_FFFF),
      go_row(),
      tick_row(CHK_WORD, pix(11, 20, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(11, 4115, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(12, 20, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(10, 20, 32'hA5A5_A5A5, 0)),
      reg_row(REG_EXTENT_H, 32'h0000_0001),
      tick_row(CHK_WORD, pix(12, 21, 32'hA5A5_A5A5, 0)),
      tick_row(CHK_WORD, pix(10, 21, 32'hA5A5_A5A5, 1)),
      // gradient with zero steps, channels saturating both ways
      reg_row(REG_DRAW_MODE, 32'h0000_0003),
      reg_row(REG_ORIGIN_X, 32'hFFFF_F000),
      reg_row(REG_ORIGIN_Y, 32'hFFFF_F000),
      reg_row(REG_EXTENT_W, 32'h0000_0002),
      reg_row(REG_EXTENT_H, 32'h0000_0002),
      reg_row(REG_COLOR_A, 32'h00FF_0080),
      reg_row(REG_COLOR_B, 32'hFF00_FF80),
      reg_row(REG_GRAD_STEPS, 32'hFFFF_E000),
      go_row(),
      tick_row(CHK_MODEL, '0),
      tick_row(CHK_MODEL, '0),
      tick_row(CHK_MODEL, '0),
      tick_row(CHK_MODEL, '0)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        if (!prev_reg) settle();
        write_reg(script[i].idx, script[i].wdata);
      end else begin
        if (prev_reg) cfg_if.valid <= 1'b0;
        push_word(script[i].kind == ROW_START, script[i].chk, script[i].word);
      end
      prev_reg = (script[i].kind == ROW_REG);
    end

    // random commands, mostly small, with restarts and live register changes
    while (n_items < ITEMS) begin
      calm = (n_items >= ITEMS - CALM_ITEMS);
      settle();
      for (int k = 0; k <= REG_GRAD_STEPS; k++) begin
        if ($urandom_range(0, 2) != 0) write_reg(cfg_idx_t'(k), reg_value(cfg_idx_t'(k)));
      end
      cfg_if.valid <= 1'b0;
      push_word(1'b1, CHK_MODEL, '0);
      if ($urandom_range(0, 9) == 0) push_word(1'b1, CHK_MODEL, '0);
      cap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 40;
      n = 0;
      while (drawing && n < cap) begin
        if ($urandom_range(0, 24) == 0) begin
          settle();
          idx = cfg_idx_t'($urandom_range(0, REG_GRAD_STEPS));
          write_reg(idx, reg_value(idx));
          cfg_if.valid <= 1'b0;
        end
        push_word(1'b0, CHK_MODEL, '0);
        n++;
      end
      if ($urandom_range(0, 4) == 0) push_word(1'b0, CHK_MODEL, '0);
    end

    quiet_tail = 1;
    settle();
    $display("drove %0d words (%0d starts), checked %0d pixels ending %0d commands",
             n_items, n_starts, n_pixels, n_ends);
    if (fail_cnt == 0) begin
      $display("PASS line_rect_gradient_drawer_core");
    end else begin
      $display("FAIL line_rect_gradient_drawer_core");
    end
    $finish;
  end

endmodule
